>>> rtl/core/sbc_pkg.sv
// Shared types, constants and drive table for the sensorless BLDC commutator.
`timescale 1ns / 1ps

package sbc_pkg;

	localparam int MAX_FILTER_SAMPLES = 8;
	localparam int SAMPLE_W           = 8;
	localparam int IV_W               = 20;
	localparam int PERIOD_W           = 16;
	localparam int CNT_W              = 18;

	localparam logic [IV_W-1:0] IV_MAX = {IV_W{1'b1}};

	// x / 6 == (x * ceil(2^23 / 6)) >> 23, exact for x < 2^21
	localparam int                DIV6_SHIFT = 23;
	localparam logic [20:0]       DIV6_MUL   = 21'd1398102;
	localparam int                DIV6_PROD_W = IV_W + 21;

	localparam logic [3:0]        FILTER_RST  = 4'd3;
	localparam logic [7:0]        STARTUP_RST = 8'd60;
	localparam logic [IV_W-1:0]   TIMEOUT_RST = 20'd50000;
	localparam logic [IV_W-1:0]   AVG_RST     = 20'd10000;

	localparam logic [1:0] CFG_FILTER  = 2'd0;
	localparam logic [1:0] CFG_STARTUP = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT = 2'd2;

	localparam logic [1:0] DRV_FLOAT = 2'd0;
	localparam logic [1:0] DRV_LOW   = 2'd1;
	localparam logic [1:0] DRV_PWM   = 2'd2;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_OPEN    = 2'd1,
		MODE_CLOSED  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ZC_NONE     = 2'd0,
		ZC_ACCEPTED = 2'd1,
		ZC_EARLY    = 2'd2,
		ZC_UNSTABLE = 2'd3
	} zc_t;

	typedef struct packed {
		logic [3:0]      filter_samples;
		logic [7:0]      startup_steps;
		logic [IV_W-1:0] timeout_us;
	} cfg_t;

	typedef struct packed {
		logic                enable;
		logic [PERIOD_W-1:0] step_period_us;
		logic                zc_edge;
		logic [SAMPLE_W-1:0] comp_samples;
	} item_t;

	typedef struct packed {
		logic [1:0]      phase_a;
		logic [1:0]      phase_b;
		logic [1:0]      phase_c;
		logic            expect_rising;
		logic [1:0]      run_mode;
		logic            commutated;
		logic [1:0]      zc_status;
		logic            timed_out;
		logic [IV_W-1:0] interval_us;
	} res_t;

	// Pattern of the step before step_index, returned as {c, b, a}
	function automatic logic [5:0] phase_drive(input logic [2:0] step);
		logic [5:0] d;
		case (step)
			3'd0:    d = {DRV_LOW,   DRV_FLOAT, DRV_PWM};
			3'd1:    d = {DRV_FLOAT, DRV_LOW,   DRV_PWM};
			3'd2:    d = {DRV_PWM,   DRV_LOW,   DRV_FLOAT};
			3'd3:    d = {DRV_PWM,   DRV_FLOAT, DRV_LOW};
			3'd4:    d = {DRV_FLOAT, DRV_PWM,   DRV_LOW};
			3'd5:    d = {DRV_LOW,   DRV_PWM,   DRV_FLOAT};
			3'd6:    d = {DRV_LOW,   DRV_FLOAT, DRV_PWM};
			default: d = {DRV_FLOAT, DRV_LOW,   DRV_PWM};
		endcase
		return d;
	endfunction

endpackage

>>> rtl/core/sbc_zc_filter.sv
// Comparator sample stability check for a back-EMF edge.
`timescale 1ns / 1ps

module sbc_zc_filter (
	input  logic [3:0]                  filter_samples,
	input  logic                        rising,
	input  logic [sbc_pkg::SAMPLE_W-1:0] samples,
	output logic                        stable
);

	logic [3:0]                   n_use;
	logic [sbc_pkg::SAMPLE_W-1:0] mask;
	logic                         want;

	always_comb begin
		n_use = (filter_samples > 4'(sbc_pkg::MAX_FILTER_SAMPLES)) ?
			4'(sbc_pkg::MAX_FILTER_SAMPLES) : filter_samples;
		for (int i = 0; i < sbc_pkg::SAMPLE_W; i++) begin
			mask[i] = (4'(i) < n_use);
		end
		want   = ~rising;
		stable = (((samples ^ {sbc_pkg::SAMPLE_W{want}}) & mask) == '0);
	end

endmodule

>>> rtl/core/sbc_ctrl.sv
// Commutation state registers and single-pass next-state logic.
`timescale 1ns / 1ps

module sbc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  sbc_pkg::item_t item,
	input  sbc_pkg::cfg_t  cfg,
	output sbc_pkg::res_t  res
);

	sbc_pkg::mode_t                 mode_q, n_mode, cur_mode;
	logic [2:0]                     step_q, n_step, step_next;
	logic [7:0]                     scount_q, n_scount;
	logic [sbc_pkg::PERIOD_W-1:0]   owait_q, n_owait, cur_wait;
	logic [sbc_pkg::IV_W-1:0]       since_q, n_since, since_inc;
	logic [sbc_pkg::IV_W-1:0]       avg_q, n_avg;
	logic [sbc_pkg::CNT_W-1:0]      cnt_q, n_cnt, cnt_eff, avg_div6;
	logic                           armed_q, n_armed;
	logic                           pend_q, n_pend;
	logic                           rising_q, n_rising;
	logic [sbc_pkg::DIV6_PROD_W-1:0] div_prod;
	logic [sbc_pkg::IV_W+1:0]       acc_sum;
	logic                           fire, rise_chk, stable, early;
	logic                           comm, tout;
	sbc_pkg::zc_t                   status;

	// countdown is loaded one tick late from the stored average
	assign div_prod  = sbc_pkg::DIV6_PROD_W'(avg_q) *
		sbc_pkg::DIV6_PROD_W'(sbc_pkg::DIV6_MUL);
	assign avg_div6  = div_prod[sbc_pkg::DIV6_SHIFT +: sbc_pkg::CNT_W];
	assign cnt_eff   = pend_q ? avg_div6 : cnt_q;
	assign fire      = armed_q && (cnt_eff <= sbc_pkg::CNT_W'(1));
	assign step_next = (step_q >= 3'd5) ? 3'd0 : step_q + 3'd1;
	assign rise_chk  = fire ? ~step_q[0] : rising_q;
	assign since_inc = (since_q == sbc_pkg::IV_MAX) ? since_q :
		since_q + sbc_pkg::IV_W'(1);
	assign early     = since_inc < (avg_q >> 1);
	assign acc_sum   = (sbc_pkg::IV_W+2)'(since_inc) + (sbc_pkg::IV_W+2)'({avg_q, 1'b0}) +
		(sbc_pkg::IV_W+2)'(avg_q);

	sbc_zc_filter u_filter (
		.filter_samples (cfg.filter_samples),
		.rising         (rise_chk),
		.samples        (item.comp_samples),
		.stable         (stable)
	);

	always_comb begin
		n_mode   = mode_q;
		n_step   = step_q;
		n_scount = scount_q;
		n_owait  = owait_q;
		n_since  = since_q;
		n_avg    = avg_q;
		n_cnt    = cnt_q;
		n_armed  = armed_q;
		n_pend   = 1'b0;
		n_rising = rising_q;
		comm     = 1'b0;
		tout     = 1'b0;
		status   = sbc_pkg::ZC_NONE;
		cur_mode = mode_q;
		cur_wait = owait_q;
		if (!item.enable) begin
			n_mode   = sbc_pkg::MODE_STOPPED;
			n_step   = 3'd0;
			n_scount = '0;
			n_owait  = '0;
			n_since  = '0;
			n_armed  = 1'b0;
			n_cnt    = '0;
		end else begin
			if (mode_q == sbc_pkg::MODE_STOPPED) begin
				cur_mode = sbc_pkg::MODE_OPEN;
				cur_wait = '0;
				n_mode   = sbc_pkg::MODE_OPEN;
				n_owait  = '0;
			end
			if (cur_mode == sbc_pkg::MODE_OPEN) begin
				if (cur_wait > sbc_pkg::PERIOD_W'(1)) begin
					n_owait = cur_wait - sbc_pkg::PERIOD_W'(1);
				end else if (scount_q >= cfg.startup_steps) begin
					n_mode  = sbc_pkg::MODE_CLOSED;
					n_avg   = sbc_pkg::IV_W'(item.step_period_us);
					n_since = '0;
					n_armed = 1'b0;
					n_cnt   = '0;
					n_owait = '0;
				end else begin
					n_rising = ~step_q[0];
					n_step   = step_next;
					comm     = 1'b1;
					n_scount = (scount_q == 8'hFF) ? scount_q : scount_q + 8'd1;
					n_owait  = item.step_period_us;
				end
			end else begin
				if (armed_q) begin
					if (fire) begin
						n_cnt    = '0;
						n_armed  = 1'b0;
						n_rising = ~step_q[0];
						n_step   = step_next;
						comm     = 1'b1;
					end else begin
						n_cnt = cnt_eff - sbc_pkg::CNT_W'(1);
					end
				end
				n_since = since_inc;
				if (item.zc_edge) begin
					if (early) begin
						status = sbc_pkg::ZC_EARLY;
					end else if (!stable) begin
						status = sbc_pkg::ZC_UNSTABLE;
					end else begin
						status  = sbc_pkg::ZC_ACCEPTED;
						n_avg   = acc_sum[sbc_pkg::IV_W+1:2];
						n_since = '0;
						n_armed = 1'b1;
						n_pend  = 1'b1;
					end
				end
				if (n_since > cfg.timeout_us) begin
					tout     = 1'b1;
					n_mode   = sbc_pkg::MODE_OPEN;
					n_scount = '0;
					n_owait  = '0;
					n_armed  = 1'b0;
					n_cnt    = '0;
					n_pend   = 1'b0;
				end
			end
		end
	end

	always_comb begin
		if (n_mode == sbc_pkg::MODE_STOPPED) begin
			{res.phase_c, res.phase_b, res.phase_a} = '0;
		end else begin
			{res.phase_c, res.phase_b, res.phase_a} = sbc_pkg::phase_drive(n_step);
		end
		res.expect_rising = n_rising;
		res.run_mode      = n_mode;
		res.commutated    = comm;
		res.zc_status     = status;
		res.timed_out     = tout;
		res.interval_us   = n_avg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= sbc_pkg::MODE_STOPPED;
			step_q   <= 3'd0;
			scount_q <= '0;
			owait_q  <= '0;
			since_q  <= '0;
			avg_q    <= sbc_pkg::AVG_RST;
			cnt_q    <= '0;
			armed_q  <= 1'b0;
			pend_q   <= 1'b0;
			rising_q <= 1'b1;
		end else if (adv) begin
			mode_q   <= n_mode;
			step_q   <= n_step;
			scount_q <= n_scount;
			owait_q  <= n_owait;
			since_q  <= n_since;
			avg_q    <= n_avg;
			cnt_q    <= n_cnt;
			armed_q  <= n_armed;
			pend_q   <= n_pend;
			rising_q <= n_rising;
		end
	end

`ifndef NO_ASSERTIONS
	a_armed_closed: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> (mode_q == sbc_pkg::MODE_CLOSED))
		else $error("commutation scheduled outside closed loop");
	a_pend_armed: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> armed_q)
		else $error("pending countdown load without schedule");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 3'd5)
		else $error("step index out of range");
`endif

endmodule

>>> rtl/core/sensorless_bldc_commutator_core.sv
// An accepted beat is held in the input register, then its result is captured in the result register.
// Throughput: one beat per cycle unless m_axis_tready stalls; single state pass per tick.
// The scheduled-commutation countdown is loaded from the stored average one tick late.
// Reset (arst_n low): stopped, average 10000, registers at defaults.
// Registers reset to filter_samples 3, startup_steps 60, timeout_us 50000.
`timescale 1ns / 1ps

module sensorless_bldc_commutator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] enable, [16:1] step_period_us, [17] zc_edge, [25:18] comp_samples
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] phase_a, [3:2] phase_b, [5:4] phase_c, [6] expect_rising,
	// [8:7] run_mode, [9] commutated, [11:10] zc_status, [12] timed_out,
	// [32:13] interval_us
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [19:0] cfg_wdata
);

	sbc_pkg::cfg_t  cfg_q;
	sbc_pkg::item_t item_s1;
	sbc_pkg::res_t  res_next, res_q;
	logic           valid_s1, out_valid_q, adv;

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, res_q.interval_us, res_q.timed_out, res_q.zc_status,
		res_q.commutated, res_q.run_mode, res_q.expect_rising,
		res_q.phase_c, res_q.phase_b, res_q.phase_a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_samples <= sbc_pkg::FILTER_RST;
			cfg_q.startup_steps  <= sbc_pkg::STARTUP_RST;
			cfg_q.timeout_us     <= sbc_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				sbc_pkg::CFG_FILTER:  cfg_q.filter_samples <= cfg_wdata[3:0];
				sbc_pkg::CFG_STARTUP: cfg_q.startup_steps  <= cfg_wdata[7:0];
				sbc_pkg::CFG_TIMEOUT: cfg_q.timeout_us     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.enable         <= s_axis_tdata[0];
			item_s1.step_period_us <= s_axis_tdata[16:1];
			item_s1.zc_edge        <= s_axis_tdata[17];
			item_s1.comp_samples   <= s_axis_tdata[25:18];
		end
		if (adv) begin
			res_q <= res_next;
		end
	end

	sbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_next)
	);

`ifndef NO_ASSERTIONS
	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid)
		else $error("advanced beat did not reach the result register");
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("input stage dropped a beat");
	a_tout_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_q.timed_out) |-> (res_q.run_mode == sbc_pkg::MODE_OPEN))
		else $error("timeout without fallback to open loop");
	a_acc_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (res_q.zc_status == sbc_pkg::ZC_ACCEPTED))
		|-> (res_q.run_mode == sbc_pkg::MODE_CLOSED))
		else $error("accepted crossing outside closed loop");
`endif

endmodule

>>> tb/tb_sensorless_bldc_commutator_core.sv
// Self-checking testbench for the sensorless BLDC six-step commutator core.
`timescale 1ns / 1ps

module tb_sensorless_bldc_commutator_core;
	import sbc_pkg::*;

	// Tracks commutator state per tick and holds the drive beats still due.
	class commutator_shadow;
		logic [3:0]  filt_n;
		logic [7:0]  startup_lim;
		logic [19:0] timeout_lim;
		mode_t       mode;
		logic [2:0]  step;
		logic [7:0]  startup_cnt;
		logic [15:0] open_wait;
		logic [19:0] since_zc;
		logic [19:0] avg_iv;
		logic [17:0] adv_cnt;
		logic        adv_armed;
		logic        rising;
		res_t        pending_drive[$];
		int          errors;
		int          beats;

		function new();
			filt_n      = FILTER_RST;
			startup_lim = STARTUP_RST;
			timeout_lim = TIMEOUT_RST;
			mode        = MODE_STOPPED;
			step        = 3'd0;
			startup_cnt = 8'd0;
			open_wait   = 16'd0;
			since_zc    = 20'd0;
			avg_iv      = AVG_RST;
			adv_cnt     = 18'd0;
			adv_armed   = 1'b0;
			rising      = 1'b1;
			errors      = 0;
			beats       = 0;
		endfunction

		function void set_reg(input logic [1:0] idx, input logic [19:0] val);
			case (idx)
				CFG_FILTER:  filt_n = val[3:0];
				CFG_STARTUP: startup_lim = val[7:0];
				CFG_TIMEOUT: timeout_lim = val;
				default: ;
			endcase
		endfunction

		function void commutate();
			rising = ~step[0];
			step   = (step == 3'd5) ? 3'd0 : step + 3'd1;
		endfunction

		// level the samples must hold on the next tick, after any scheduled commutation
		function logic edge_level();
			if (adv_armed && adv_cnt <= 18'd1)
				return step[0];
			return ~rising;
		endfunction

		function bit samples_ok(input logic [7:0] smp);
			int n;
			n = int'(filt_n);
			if (n > MAX_FILTER_SAMPLES) n = MAX_FILTER_SAMPLES;
			if (n > 8) n = 8;
			for (int i = 0; i < n; i++)
				if (smp[i] !== ~rising) return 1'b0;
			return 1'b1;
		endfunction

		function void accept_tick(input logic en, input logic [15:0] per, input logic zc,
				input logic [7:0] smp);
			res_t        r;
			logic        comm;
			zc_t         st;
			logic        tout;
			logic [23:0] acc;
			logic [5:0]  drv;
			comm = 1'b0;
			st   = ZC_NONE;
			tout = 1'b0;
			if (!en) begin
				mode        = MODE_STOPPED;
				step        = 3'd0;
				startup_cnt = 8'd0;
				open_wait   = 16'd0;
				since_zc    = 20'd0;
				adv_armed   = 1'b0;
				adv_cnt     = 18'd0;
			end else begin
				if (mode == MODE_STOPPED) begin
					mode      = MODE_OPEN;
					open_wait = 16'd0;
				end
				if (mode == MODE_OPEN) begin
					if (open_wait > 16'd1) begin
						open_wait = open_wait - 16'd1;
					end else if (startup_cnt >= startup_lim) begin
						mode      = MODE_CLOSED;
						avg_iv    = {4'd0, per};
						since_zc  = 20'd0;
						adv_armed = 1'b0;
						adv_cnt   = 18'd0;
						open_wait = 16'd0;
					end else begin
						commutate();
						comm = 1'b1;
						if (startup_cnt != 8'hFF) startup_cnt = startup_cnt + 8'd1;
						open_wait = per;
					end
				end else begin
					if (adv_armed) begin
						if (adv_cnt <= 18'd1) begin
							adv_cnt   = 18'd0;
							adv_armed = 1'b0;
							commutate();
							comm = 1'b1;
						end else begin
							adv_cnt = adv_cnt - 18'd1;
						end
					end
					if (since_zc != IV_MAX) since_zc = since_zc + 20'd1;
					if (zc) begin
						if (since_zc < avg_iv / 20'd2) begin
							st = ZC_EARLY;
						end else if (!samples_ok(smp)) begin
							st = ZC_UNSTABLE;
						end else begin
							st        = ZC_ACCEPTED;
							acc       = 24'(since_zc) + 24'(avg_iv) * 24'd3;
							avg_iv    = acc[21:2];
							since_zc  = 20'd0;
							adv_cnt   = 18'(avg_iv / 20'd6);
							adv_armed = 1'b1;
						end
					end
					if (since_zc > timeout_lim) begin
						tout        = 1'b1;
						mode        = MODE_OPEN;
						startup_cnt = 8'd0;
						open_wait   = 16'd0;
						adv_armed   = 1'b0;
						adv_cnt     = 18'd0;
					end
				end
			end
			// {c, b, a} for the step before the current one
			case (step)
				3'd0:    drv = {DRV_LOW,   DRV_FLOAT, DRV_PWM};
				3'd1:    drv = {DRV_FLOAT, DRV_LOW,   DRV_PWM};
				3'd2:    drv = {DRV_PWM,   DRV_LOW,   DRV_FLOAT};
				3'd3:    drv = {DRV_PWM,   DRV_FLOAT, DRV_LOW};
				3'd4:    drv = {DRV_FLOAT, DRV_PWM,   DRV_LOW};
				default: drv = {DRV_LOW,   DRV_PWM,   DRV_FLOAT};
			endcase
			if (mode == MODE_STOPPED)
				drv = {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT};
			r.phase_a       = drv[1:0];
			r.phase_b       = drv[3:2];
			r.phase_c       = drv[5:4];
			r.expect_rising = rising;
			r.run_mode      = mode;
			r.commutated    = comm;
			r.zc_status     = st;
			r.timed_out     = tout;
			r.interval_us   = avg_iv;
			pending_drive.push_back(r);
		endfunction

		task report(input string msg);
			if (errors < 50)
				$display("ERROR @%0t beat %0d: %s", $realtime, beats, msg);
			errors++;
		endtask

		task cmp(input string nm, input logic [19:0] got, input logic [19:0] want);
			if (got !== want)
				report($sformatf("%s got %0h want %0h", nm, got, want));
		endtask

		task check_beat(input logic [39:0] d);
			res_t e;
			if (pending_drive.size() == 0) begin
				report("result beat with no tick pending");
			end else begin
				e = pending_drive.pop_front();
				cmp("phase_a",       20'(d[1:0]),   20'(e.phase_a));
				cmp("phase_b",       20'(d[3:2]),   20'(e.phase_b));
				cmp("phase_c",       20'(d[5:4]),   20'(e.phase_c));
				cmp("expect_rising", 20'(d[6]),     20'(e.expect_rising));
				cmp("run_mode",      20'(d[8:7]),   20'(e.run_mode));
				cmp("commutated",    20'(d[9]),     20'(e.commutated));
				cmp("zc_status",     20'(d[11:10]), 20'(e.zc_status));
				cmp("timed_out",     20'(d[12]),    20'(e.timed_out));
				cmp("interval_us",   d[32:13],      e.interval_us);
			end
			beats++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [19:0] cfg_wdata;
	bit          calm;

	commutator_shadow sb;

	sensorless_bldc_commutator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 35);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_beat(m_axis_tdata);
	end

	task automatic send_tick(input logic en, input logic [15:0] per, input logic zc,
			input logic [7:0] smp);
		while (!calm && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, smp, zc, per, en};
		do @(posedge clk); while (!s_axis_tready);
		sb.accept_tick(en, per, zc, smp);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_drive.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [19:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic set_config(input int f, input int s, input int t);
		put_reg(CFG_FILTER, 20'(f));
		put_reg(CFG_STARTUP, 20'(s));
		put_reg(CFG_TIMEOUT, 20'(t));
		cfg_we <= 1'b0;
	endtask

	// stable comparator pattern for the next tick, noise above the filter window
	function automatic logic [7:0] good_samples(input logic [7:0] noise);
		logic [7:0] mask;
		int n;
		n    = (sb.filt_n > 4'd8) ? 8 : int'(sb.filt_n);
		mask = 8'((1 << n) - 1);
		return sb.edge_level() ? (noise | mask) : (noise & ~mask);
	endfunction

	task automatic random_tick(input logic [15:0] per, input bit quiet);
		logic        en;
		logic        zc;
		logic [15:0] p;
		logic [7:0]  smp;
		int          r;
		r   = $urandom_range(99);
		en  = 1'b1;
		p   = per;
		zc  = 1'b0;
		smp = 8'($urandom_range(255));
		if (r < 10) begin
			en = ($urandom_range(39) != 0);
			zc = 1'($urandom_range(1));
			if (!en || sb.mode == MODE_CLOSED) p = 16'($urandom_range(16'hFFFF));
		end else if (sb.mode == MODE_CLOSED) begin
			if (!quiet && r < 45 && int'(sb.since_zc) + 1 >= int'(sb.avg_iv) / 2) begin
				zc  = 1'b1;
				smp = good_samples(smp);
			end else if (r >= 94) begin
				zc = 1'b1;
			end
		end else if (r < 20) begin
			zc = 1'b1;
		end
		send_tick(en, p, zc, smp);
	endtask

	task automatic run_phase(input int f, input int s, input int t, input int pmax,
			input int rmin, input int rmax, input int budget, input bit no_gaps);
		int          done;
		int          len;
		int          stops;
		logic [15:0] per;
		bit          quiet;
		wait_idle();
		set_config(f, s, t);
		calm = no_gaps;
		done = 0;
		while (done < budget) begin
			per   = 16'(($urandom_range(99) < 85) ? $urandom_range(pmax) :
				$urandom_range(pmax * 10));
			quiet = ($urandom_range(99) < 20);
			len   = $urandom_range(rmax, rmin);
			if (len > budget - done) len = budget - done;
			stops = $urandom_range(3, 1);
			repeat (len) random_tick(per, quiet);
			repeat (stops)
				send_tick(1'b0, 16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
					8'($urandom_range(255)));
			done += len + stops;
		end
		calm = 1'b0;
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = CFG_FILTER;
		cfg_wdata     = '0;
		calm          = 1'b0;
		sb            = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stopped with all fields high, open-loop entry with longest period, stop
		send_tick(1'b0, 16'hFFFF, 1'b1, 8'hFF);
		send_tick(1'b1, 16'hFFFF, 1'b1, 8'h00);
		send_tick(1'b0, 16'h0000, 1'b0, 8'h00);

		// two open steps, closed loop, early / unstable / accepted edge, timeout
		wait_idle();
		set_config(2, 2, 12);
		send_tick(1'b1, 16'd0, 1'b0, 8'h00);
		send_tick(1'b1, 16'd1, 1'b0, 8'h00);
		send_tick(1'b1, 16'd4, 1'b0, 8'h00);
		send_tick(1'b1, 16'd4, 1'b1, good_samples(8'h00));
		send_tick(1'b1, 16'd4, 1'b1, ~good_samples(8'h00));
		send_tick(1'b1, 16'd4, 1'b1, good_samples(8'h00));
		repeat (13) send_tick(1'b1, 16'd4, 1'b0, 8'h00);
		send_tick(1'b1, 16'd4, 1'b0, 8'h00);

		// no startup steps, zero filter and zero timeout
		wait_idle();
		set_config(0, 0, 0);
		send_tick(1'b1, 16'd1, 1'b0, 8'h00);
		send_tick(1'b1, 16'd1, 1'b1, 8'h3C);
		send_tick(1'b1, 16'd1, 1'b0, 8'h00);
		send_tick(1'b1, 16'd1, 1'b0, 8'h00);
		send_tick(1'b0, 16'd0, 1'b0, 8'h00);

		run_phase(3, 60, 50000, 2, 150, 300, 300, 1'b0);
		run_phase(1, 1, 1, 40, 20, 80, 230, 1'b0);
		run_phase(8, 255, 1048575, 1, 350, 450, 450, 1'b1);
		run_phase(15, 4, 300, 30, 40, 150, 220, 1'b0);
		run_phase(0, 0, 0, 40, 20, 80, 220, 1'b0);
		run_phase($urandom_range(15), $urandom_range(12), $urandom_range(800, 30),
			40, 40, 150, 220, 1'b0);
		run_phase($urandom_range(15), $urandom_range(12), $urandom_range(800, 30),
			40, 40, 150, 220, 1'b0);

		wait_idle();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
